FILE: design/mhic_pkg.sv
// Shared types and constants for the magnetometer hard-iron calibration block
`default_nettype none
package mhic_pkg;

  localparam int NUM_AXES  = 3;
  localparam int AXIS_X    = 0;
  localparam int AXIS_Y    = 1;
  localparam int AXIS_Z    = 2;

  localparam int TIME_BITS     = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CAL_WINDOW   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_APPLY_OFFSET = 1'd1;

  localparam logic [TIME_BITS-1:0] CAL_WINDOW_RESET = 32'd30000000;

  // per-item controls from the window logic to the axis lanes
  typedef struct packed {
    logic seed;    // start of calibration: clear offset, seed extremes
    logic apply;   // subtract stored offset
    logic track;   // window open after this item
    logic finish;  // window closed on this item
  } lane_ctl_t;

endpackage
`default_nettype wire

FILE: design/mhic_if.sv
// Item channel interfaces for samples in and corrected results out
`default_nettype none
interface mhic_in_if import mhic_pkg::*; #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;
  logic [TIME_BITS-1:0]          time_us;
  logic                          start_cal;

  modport source (output valid, sample_x, sample_y, sample_z, time_us, start_cal,
                  input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, time_us, start_cal,
                  output ready);
endinterface

interface mhic_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] corr_x;
  logic signed [SAMPLE_BITS-1:0] corr_y;
  logic signed [SAMPLE_BITS-1:0] corr_z;
  logic                          healthy;
  logic                          calibrating;
  logic                          cal_done;
  logic signed [SAMPLE_BITS-1:0] zero_x;
  logic signed [SAMPLE_BITS-1:0] zero_y;
  logic signed [SAMPLE_BITS-1:0] zero_z;

  modport source (output valid, corr_x, corr_y, corr_z, healthy, calibrating, cal_done,
                  zero_x, zero_y, zero_z, input ready);
  modport sink   (input valid, corr_x, corr_y, corr_z, healthy, calibrating, cal_done,
                  zero_x, zero_y, zero_z, output ready);
endinterface
`default_nettype wire

FILE: design/mhic_ctrl.sv
// Configuration registers and calibration window timing
`default_nettype none
module mhic_ctrl import mhic_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     accept,
  input  wire logic                     start,
  input  wire logic [TIME_BITS-1:0]     now,
  output lane_ctl_t                     ctl
);

  logic [TIME_BITS-1:0] cal_window;
  logic                 apply;
  logic [TIME_BITS-1:0] cal_start_time;
  logic                 cal_active;

  logic [TIME_BITS-1:0] base;
  logic [TIME_BITS-1:0] elapsed;
  logic                 running;
  logic                 in_window;

  always_comb begin
    base       = start ? now : cal_start_time;
    elapsed    = now - base;
    in_window  = elapsed < cal_window;
    running    = start | cal_active;
    ctl.seed   = start;
    ctl.apply  = apply;
    ctl.track  = running & in_window;
    ctl.finish = running & ~in_window;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_window     <= CAL_WINDOW_RESET;
      apply          <= 1'b1;
      cal_start_time <= '0;
      cal_active     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CAL_WINDOW:   cal_window <= cfg_data[TIME_BITS-1:0];
          CFG_APPLY_OFFSET: apply      <= cfg_data[0];
          default:          ;
        endcase
      end
      if (accept) begin
        if (start) cal_start_time <= now;
        cal_active <= ctl.track;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/mhic_lane.sv
// One axis lane: offset correction, extreme tracking and offset computation
`default_nettype none
module mhic_lane import mhic_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire lane_ctl_t                     ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0]      corr,
  output logic signed [SAMPLE_BITS-1:0]      zero_next
);

  localparam int SUM_BITS = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] offset;
  logic signed [SAMPLE_BITS-1:0] amin;
  logic signed [SAMPLE_BITS-1:0] amax;

  logic signed [SAMPLE_BITS-1:0] off_eff;
  logic signed [SAMPLE_BITS-1:0] min_eff;
  logic signed [SAMPLE_BITS-1:0] max_eff;
  logic signed [SAMPLE_BITS-1:0] min_next;
  logic signed [SAMPLE_BITS-1:0] max_next;
  logic signed [SAMPLE_BITS-1:0] mid;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    sum_adj;

  always_comb begin
    off_eff = ctl.seed ? '0 : offset;
    min_eff = ctl.seed ? sample : amin;
    max_eff = ctl.seed ? sample : amax;
    corr    = ctl.apply ? (sample - off_eff) : sample;

    // midpoint, rounded toward zero
    sum     = {min_eff[SAMPLE_BITS-1], min_eff} + {max_eff[SAMPLE_BITS-1], max_eff};
    sum_adj = sum + {{SAMPLE_BITS{1'b0}}, sum[SUM_BITS-1] & sum[0]};
    mid     = sum_adj[SUM_BITS-1:1];

    min_next  = (ctl.track && corr < min_eff) ? corr : min_eff;
    max_next  = (ctl.track && corr > max_eff) ? corr : max_eff;
    zero_next = ctl.finish ? mid : off_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      amin   <= '0;
      amax   <= '0;
    end else if (accept) begin
      offset <= zero_next;
      amin   <= min_next;
      amax   <= max_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/mhic_merge.sv
// Merging stage: combines lane results into the registered output item
`default_nettype none
module mhic_merge import mhic_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire lane_ctl_t                     ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] corr [NUM_AXES],
  input  wire logic signed [SAMPLE_BITS-1:0] zero [NUM_AXES],
  output logic                               open,
  mhic_out_if.source                         out_ch
);

  logic all_nonzero;

  always_comb begin
    all_nonzero = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      all_nonzero = all_nonzero & (corr[a] != '0);
    end
    open = ~out_ch.valid | out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (open) begin
      out_ch.valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.corr_x      <= corr[AXIS_X];
      out_ch.corr_y      <= corr[AXIS_Y];
      out_ch.corr_z      <= corr[AXIS_Z];
      out_ch.healthy     <= all_nonzero;
      out_ch.calibrating <= ctl.track;
      out_ch.cal_done    <= ctl.finish;
      out_ch.zero_x      <= zero[AXIS_X];
      out_ch.zero_y      <= zero[AXIS_Y];
      out_ch.zero_z      <= zero[AXIS_Z];
    end
  end

endmodule
`default_nettype wire

FILE: design/magnetometer_hard_iron_calibration.sv
// Top level of the magnetometer hard-iron calibration block
// Takes one sample item per clock while the output is free and returns its
// corrected item in the cycle after acceptance; the per-axis min/max update
// and the 32-bit window compare are combinational. Three axis lanes
// run side by side and a merging stage registers the result; a new item is
// taken only after the last result is taken (ready = output empty or taken).
// cal_window_us (index 0) and apply_offset (index 1) are written through
// cfg_we/cfg_idx/cfg_data, by the user only while no item is in flight (not
// enforced by the block). No clearing pass after reset is needed.
`default_nettype none
module magnetometer_hard_iron_calibration import mhic_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  mhic_in_if.sink                       in_ch,
  mhic_out_if.source                    out_ch
);

  lane_ctl_t                     ctl;
  logic                          accept;
  logic                          open;
  logic signed [SAMPLE_BITS-1:0] sample [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] corr   [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] zero   [NUM_AXES];

  assign in_ch.ready = open;
  assign accept      = in_ch.valid & open;

  assign sample[AXIS_X] = in_ch.sample_x;
  assign sample[AXIS_Y] = in_ch.sample_y;
  assign sample[AXIS_Z] = in_ch.sample_z;

  mhic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .accept   (accept),
    .start    (in_ch.start_cal),
    .now      (in_ch.time_us),
    .ctl      (ctl)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mhic_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .ctl       (ctl),
      .sample    (sample[a]),
      .corr      (corr[a]),
      .zero_next (zero[a])
    );
  end

  mhic_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ctl    (ctl),
    .corr   (corr),
    .zero   (zero),
    .open   (open),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

FILE: design/mhic_checker.sv
// Port-level checks for the hard-iron calibration block and their binding
`default_nettype none
module mhic_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [SAMPLE_BITS-1:0] corr_x,
  input wire logic signed [SAMPLE_BITS-1:0] corr_y,
  input wire logic signed [SAMPLE_BITS-1:0] corr_z,
  input wire logic                          healthy,
  input wire logic                          calibrating,
  input wire logic                          cal_done
);

  // a result item stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // an item accepted with the output free shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (!out_valid || out_ready) |=> out_valid)
    else $error("accepted item not presented");

  // empty output never blocks the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_healthy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> healthy == (corr_x != '0 && corr_y != '0 && corr_z != '0))
    else $error("healthy flag disagrees with corrected axes");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && cal_done |-> !calibrating)
    else $error("calibration still running on done item");

endmodule

bind magnetometer_hard_iron_calibration mhic_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .corr_x      (out_ch.corr_x),
  .corr_y      (out_ch.corr_y),
  .corr_z      (out_ch.corr_z),
  .healthy     (out_ch.healthy),
  .calibrating (out_ch.calibrating),
  .cal_done    (out_ch.cal_done)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the magnetometer hard-iron calibration block: directed table, then random phases
`timescale 1ns / 1ps
module tb_top import mhic_pkg::*; ();

  localparam int SB          = 16;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 6;

  typedef struct {
    logic signed [SB-1:0]  axis[NUM_AXES];
    logic [TIME_BITS-1:0]  t;
    logic                  start;
  } mag_sample_t;

  typedef struct {
    logic signed [SB-1:0]  corr[NUM_AXES];
    logic                  healthy;
    logic                  calibrating;
    logic                  done;
    logic signed [SB-1:0]  zero[NUM_AXES];
  } mag_result_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM, RX_HOLD} rx_mode_t;

  typedef struct {
    row_kind_t               kind;
    mag_sample_t             item;
    bit                      typed;
    mag_result_t             want;
    logic [CFG_IDX_BITS-1:0] sel;
    logic [CFG_DATA_BITS-1:0] val;
  } row_t;

  logic clk;
  logic rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  mhic_in_if  #(.SAMPLE_BITS(SB)) in_ch();
  mhic_out_if #(.SAMPLE_BITS(SB)) out_ch();

  magnetometer_hard_iron_calibration #(.SAMPLE_BITS(SB)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predictor copy of the block
  logic [TIME_BITS-1:0] win_us;
  logic                 apply_on;
  logic [TIME_BITS-1:0] cal_t0;
  logic                 cal_on;
  logic signed [SB-1:0] off_st[NUM_AXES];
  logic signed [SB-1:0] min_st[NUM_AXES];
  logic signed [SB-1:0] max_st[NUM_AXES];

  mag_result_t due_results[$];
  row_t        dir_rows[$];

  bit          cur_typed;
  mag_result_t cur_want;
  bit          gaps_on;
  int          burst_left;
  rx_mode_t    rx_mode;
  int          hold_n;
  logic [15:0] rx_pat;

  int errors;
  int items_sent;
  int phase_sent;
  int results_seen;
  int cals_closed;
  int unhealthy_seen;
  int settings_used;

  logic [TIME_BITS-1:0] win_set[NUM_PHASES] = '{32'd100, 32'd1, 32'd37, 32'd5000,
                                                 32'hFFFF_FFFF, 32'd30000000};
  bit apply_set[NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  rx_mode_t rx_set[NUM_PHASES] = '{RX_RANDOM, RX_PATTERN, RX_ALWAYS, RX_RANDOM,
                                   RX_PATTERN, RX_RANDOM};

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic mag_result_t predict_calibration(input mag_sample_t it);
    mag_result_t r;
    logic [TIME_BITS-1:0] el;
    int lo, hi;
    r.done = 1'b0;
    if (it.start) begin
      cal_t0 = it.t;
      cal_on = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        off_st[a] = '0;
        min_st[a] = it.axis[a];
        max_st[a] = it.axis[a];
      end
    end
    for (int a = 0; a < NUM_AXES; a++)
      r.corr[a] = apply_on ? it.axis[a] - off_st[a] : it.axis[a];
    if (cal_on) begin
      el = it.t - cal_t0;
      if (el < win_us) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if (r.corr[a] < min_st[a]) min_st[a] = r.corr[a];
          if (r.corr[a] > max_st[a]) max_st[a] = r.corr[a];
        end
      end else begin
        cal_on = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
          lo = int'(min_st[a]);
          hi = int'(max_st[a]);
          off_st[a] = SB'((lo + hi) / 2);
        end
        r.done = 1'b1;
      end
    end
    r.healthy     = (r.corr[0] != 0) && (r.corr[1] != 0) && (r.corr[2] != 0);
    r.calibrating = cal_on;
    for (int a = 0; a < NUM_AXES; a++) r.zero[a] = off_st[a];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    mag_sample_t it;
    mag_result_t got;
    mag_result_t want;
    if (rst) begin
      win_us   = CAL_WINDOW_RESET;
      apply_on = 1'b1;
      cal_t0   = '0;
      cal_on   = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        off_st[a] = '0;
        min_st[a] = '0;
        max_st[a] = '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.corr[AXIS_X] = out_ch.corr_x;
        got.corr[AXIS_Y] = out_ch.corr_y;
        got.corr[AXIS_Z] = out_ch.corr_z;
        got.zero[AXIS_X] = out_ch.zero_x;
        got.zero[AXIS_Y] = out_ch.zero_y;
        got.zero[AXIS_Z] = out_ch.zero_z;
        got.healthy      = out_ch.healthy;
        got.calibrating  = out_ch.calibrating;
        got.done         = out_ch.cal_done;
        if (due_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = due_results.pop_front();
          for (int a = 0; a < NUM_AXES; a++) begin
            if (got.corr[a] !== want.corr[a])
              report($sformatf("result %0d corr[%0d] got %0d want %0d",
                               results_seen, a, got.corr[a], want.corr[a]));
            if (got.zero[a] !== want.zero[a])
              report($sformatf("result %0d zero[%0d] got %0d want %0d",
                               results_seen, a, got.zero[a], want.zero[a]));
          end
          if (got.healthy !== want.healthy)
            report($sformatf("result %0d healthy got %b want %b",
                             results_seen, got.healthy, want.healthy));
          if (got.calibrating !== want.calibrating)
            report($sformatf("result %0d calibrating got %b want %b",
                             results_seen, got.calibrating, want.calibrating));
          if (got.done !== want.done)
            report($sformatf("result %0d cal_done got %b want %b",
                             results_seen, got.done, want.done));
          if (want.done) cals_closed++;
          if (!want.healthy) unhealthy_seen++;
        end
        results_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        it.axis[AXIS_X] = in_ch.sample_x;
        it.axis[AXIS_Y] = in_ch.sample_y;
        it.axis[AXIS_Z] = in_ch.sample_z;
        it.t            = in_ch.time_us;
        it.start        = in_ch.start_cal;
        want = predict_calibration(it);
        due_results.push_back(cur_typed ? cur_want : want);
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_CAL_WINDOW) win_us = cfg_data;
        else if (cfg_idx == CFG_APPLY_OFFSET) apply_on = cfg_data[0];
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    out_ch.ready = 1'b0;
    hold_n = 0;
    rx_pat = 16'b1101_1110_0110_1011;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ch.ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready = 1'b1;
          RX_PATTERN: begin
            out_ch.ready = rx_pat[0];
            rx_pat = {rx_pat[0], rx_pat[15:1]};
          end
          RX_RANDOM: out_ch.ready = ($urandom_range(0, 3) != 0);
          RX_HOLD: begin
            out_ch.ready = 1'b0;
            hold_n++;
            if (hold_n >= HOLD_CYCLES) begin
              hold_n  = 0;
              rx_mode = RX_RANDOM;
            end
          end
          default: out_ch.ready = 1'b1;
        endcase
      end
    end
  end

  initial begin : limit
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic mag_sample_t mk_item(input int x, input int y, input int z,
                                          input logic [TIME_BITS-1:0] t, input bit st);
    mag_sample_t it;
    it.axis[AXIS_X] = SB'(x);
    it.axis[AXIS_Y] = SB'(y);
    it.axis[AXIS_Z] = SB'(z);
    it.t            = t;
    it.start        = st;
    return it;
  endfunction

  function automatic mag_result_t mk_res(input int cx, input int cy, input int cz,
                                         input bit h, input bit c, input bit d,
                                         input int zx, input int zy, input int zz);
    mag_result_t r;
    r.corr[AXIS_X] = SB'(cx);
    r.corr[AXIS_Y] = SB'(cy);
    r.corr[AXIS_Z] = SB'(cz);
    r.healthy      = h;
    r.calibrating  = c;
    r.done         = d;
    r.zero[AXIS_X] = SB'(zx);
    r.zero[AXIS_Y] = SB'(zy);
    r.zero[AXIS_Z] = SB'(zz);
    return r;
  endfunction

  task automatic row_item(input mag_sample_t it);
    row_t r;
    r.kind  = ROW_ITEM;
    r.item  = it;
    r.typed = 1'b0;
    r.sel   = '0;
    r.val   = '0;
    dir_rows.push_back(r);
  endtask

  task automatic row_checked(input mag_sample_t it, input mag_result_t want);
    row_t r;
    r.kind  = ROW_ITEM;
    r.item  = it;
    r.typed = 1'b1;
    r.want  = want;
    r.sel   = '0;
    r.val   = '0;
    dir_rows.push_back(r);
  endtask

  task automatic row_cfg(input logic [CFG_IDX_BITS-1:0] sel,
                         input logic [CFG_DATA_BITS-1:0] val);
    row_t r;
    r.kind  = ROW_CFG;
    r.typed = 1'b0;
    r.sel   = sel;
    r.val   = val;
    dir_rows.push_back(r);
  endtask

  task automatic send(input mag_sample_t it, input bit typed, input mag_result_t want);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.sample_x  = it.axis[AXIS_X];
    in_ch.sample_y  = it.axis[AXIS_Y];
    in_ch.sample_z  = it.axis[AXIS_Z];
    in_ch.time_us   = it.t;
    in_ch.start_cal = it.start;
    cur_typed       = typed;
    cur_want        = want;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    phase_sent++;
  endtask

  // input idle until every expected result has arrived
  task automatic settle();
    in_ch.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] sel,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = sel;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [SB-1:0] pick_axis(input int a);
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SB-1){1'b1}}};
      1: return {1'b1, {(SB-1){1'b0}}};
      2: return off_st[a];
      3, 4: return SB'($urandom_range(0, 8) - 4);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic mag_sample_t rand_item(input logic [TIME_BITS-1:0] t, input bit st);
    mag_sample_t it;
    for (int a = 0; a < NUM_AXES; a++) it.axis[a] = pick_axis(a);
    it.t     = t;
    it.start = st;
    return it;
  endfunction

  // start, samples across the window, the closing sample, a few after
  task automatic run_cal_seq();
    logic [TIME_BITS-1:0] t0;
    logic [63:0] el;
    logic [63:0] step;
    mag_result_t none;
    int n;
    t0 = $urandom;
    el = '0;
    n  = 0;
    send(rand_item(t0, 1'b1), 1'b0, none);
    while (el < win_us && n < 30) begin
      step = (win_us >= 12) ? 64'($urandom_range(0, win_us / 6)) :
                              64'($urandom_range(0, 1));
      if (el + step > win_us && $urandom_range(0, 2) == 0) el = 64'(win_us);
      else el = el + step;
      send(rand_item(t0 + el[31:0], $urandom_range(0, 40) == 0), 1'b0, none);
      n++;
    end
    if (el < win_us) send(rand_item(t0 - 1, 1'b0), 1'b0, none);
    repeat ($urandom_range(1, 3))
      send(rand_item(t0 + el[31:0] + $urandom_range(0, 50), 1'b0), 1'b0, none);
  endtask

  initial begin : main
    mag_result_t none;
    bit mid_done;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_x  = '0;
    in_ch.sample_y  = '0;
    in_ch.sample_z  = '0;
    in_ch.time_us   = '0;
    in_ch.start_cal = 1'b0;
    cur_typed       = 1'b0;
    gaps_on         = 1'b0;
    burst_left      = 0;
    rx_mode         = RX_PATTERN;
    errors          = 0;
    items_sent      = 0;
    phase_sent      = 0;
    results_seen    = 0;
    cals_closed     = 0;
    unhealthy_seen  = 0;
    settings_used   = 0;

    // reset defaults: 30 s window, offsets applied
    row_checked(mk_item(32767, -32768, 1, 0, 0),
                mk_res(32767, -32768, 1, 1, 0, 0, 0, 0, 0));
    row_checked(mk_item(0, 0, 0, 7, 0), mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0));
    row_checked(mk_item(-32768, 32767, -32768, 100, 1),
                mk_res(-32768, 32767, -32768, 1, 1, 0, 0, 0, 0));
    row_item(mk_item(0, 32767, -32768, 200, 0));
    // elapsed exactly equal to the window closes it
    row_item(mk_item(0, 0, 0, 30000100, 0));
    row_item(mk_item(32767, -32768, 32767, 30000200, 0));
    row_cfg(CFG_APPLY_OFFSET, 0);
    row_checked(mk_item(32767, -32768, 32767, 30000300, 0),
                mk_res(32767, -32768, 32767, 1, 0, 0, -16384, 32767, -32768));
    row_item(mk_item(-3, 5, -1, 500, 1));
    // restart mid-window
    row_item(mk_item(-3, 4, 1, 600, 1));
    row_item(mk_item(0, 6, 2, 700, 0));
    // time steps backwards: closes the window
    row_item(mk_item(9, 9, 9, 599, 0));
    row_cfg(CFG_APPLY_OFFSET, 1);
    row_cfg(CFG_CAL_WINDOW, 0);
    row_checked(mk_item(1234, -4321, 0, 32'hFFFF_FFFF, 1),
                mk_res(1234, -4321, 0, 0, 0, 1, 1234, -4321, 0));
    row_cfg(CFG_CAL_WINDOW, 1);
    row_item(mk_item(10, 20, 30, 32'hFFFF_FFFF, 1));
    row_item(mk_item(40, -20, 30, 32'hFFFF_FFFF, 0));
    row_item(mk_item(0, 0, 0, 0, 0));
    row_item(mk_item(25, 0, 30, 1, 0));
    row_cfg(CFG_CAL_WINDOW, 32'hFFFF_FFFF);
    row_item(mk_item(5, 5, 5, 32'h8000_0000, 1));
    row_item(mk_item(7, 3, 5, 32'h8000_0001, 0));
    row_item(mk_item(7, 3, 5, 32'h7FFF_FFFF, 0));

    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].sel, dir_rows[i].val);
      end else begin
        send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_CAL_WINDOW, win_set[p]);
      write_reg(CFG_APPLY_OFFSET, CFG_DATA_BITS'(apply_set[p]));
      rx_mode    = rx_set[p];
      gaps_on    = (p != 2);
      phase_sent = 0;
      mid_done   = 1'b0;
      while (phase_sent < PHASE_ITEMS) begin
        if (!mid_done && phase_sent >= PHASE_ITEMS / 2) begin
          mid_done = 1'b1;
          if (p == 1 || p == 4) rx_mode = RX_HOLD;
          else if (p == 3) begin
            in_ch.valid = 1'b0;
            while (due_results.size() != 0) @(negedge clk);
          end
        end
        if ($urandom_range(0, 3) != 0) begin
          run_cal_seq();
        end else begin
          repeat ($urandom_range(1, 4))
            send(rand_item($urandom, $urandom_range(0, 7) == 0), 1'b0, none);
        end
      end
    end

    in_ch.valid = 1'b0;
    for (int i = 0; i < 2000 && due_results.size() != 0; i++) @(posedge clk);
    if (due_results.size() != 0)
      report($sformatf("%0d expected results never arrived", due_results.size()));
    repeat (5) @(posedge clk);

    $display("Ran %0d items under %0d register writes; %0d results checked.",
             items_sent, settings_used, results_seen);
    $display("%0d calibrations closed, %0d results with a zero axis.",
             cals_closed, unhealthy_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
